// File: hdl/mmsl_pkg.sv
// ============================================================================
// mmsl_pkg
// Shared types, widths and helpers for the mecanum mixer with slew limit.
// ============================================================================
package mmsl_pkg;

    localparam int WHEELS    = 4;
    localparam int WIDX_W    = 2;
    localparam int VEL_W     = 16;
    localparam int DEM_W     = 18;   // sum of three Q2.13 values
    localparam int MAG_W     = 17;   // magnitude of a demand
    localparam int SCALE_W   = 10;
    localparam int PROD_W    = MAG_W + SCALE_W;
    localparam int SPEED_W   = 11;
    localparam int DUTY_W    = 10;
    localparam int STEP_W    = 11;
    localparam int MASK_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 11;
    localparam int DIV_STEPS = 10;
    localparam int CNT_W     = 4;

    localparam logic [MAG_W-1:0]   ONE_Q13         = 17'd8192;
    localparam logic [STEP_W-1:0]  RAMP_STEP_RESET = 11'd10;
    localparam logic [DUTY_W-1:0]  PWM_LIMIT_RESET = 10'd255;
    localparam logic [MASK_W-1:0]  INV_MASK_RESET  = 4'd0;
    localparam logic [CNT_W-1:0]   DIV_LAST        = 4'(DIV_STEPS - 1);
    localparam logic [WIDX_W-1:0]  WHEEL_LAST      = 2'(WHEELS - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAMP_STEP   = 2'd0,
        CFG_PWM_LIMIT   = 2'd1,
        CFG_INVERT_MASK = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DIR_OFF = 2'd0,
        DIR_FWD = 2'd1,
        DIR_REV = 2'd2
    } dir_t;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MIX  = 7'b0000010,
        ST_MAX  = 7'b0000100,
        ST_MUL  = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_SLEW = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    typedef struct packed {
        dir_t              dir;
        logic [DUTY_W-1:0] duty;
    } drive_t;

    // Clamp a signed wheel speed to +-limit and split it into direction and duty.
    function automatic drive_t speed_to_drive(input logic signed [SPEED_W-1:0] speed,
                                              input logic [DUTY_W-1:0] limit);
        drive_t             d;
        logic [SPEED_W-1:0] m;
        logic [DUTY_W-1:0]  c;
        m = speed[SPEED_W-1] ? SPEED_W'(-speed) : SPEED_W'(speed);
        c = (m > {1'b0, limit}) ? limit : m[DUTY_W-1:0];
        if (c == '0) begin
            d.dir = DIR_OFF;
        end else if (speed[SPEED_W-1]) begin
            d.dir = DIR_REV;
        end else begin
            d.dir = DIR_FWD;
        end
        d.duty = c;
        return d;
    endfunction

    function automatic logic [MAG_W-1:0] dem_mag(input logic signed [DEM_W-1:0] v);
        logic [DEM_W-1:0] a;
        a = v[DEM_W-1] ? DEM_W'(-v) : DEM_W'(v);
        return a[MAG_W-1:0];
    endfunction

endpackage

// File: hdl/mecanum_mixer_with_slew_limit_unit.sv
// ============================================================================
// mecanum_mixer_with_slew_limit_unit
// Mixes a velocity command into four slew-limited mecanum wheel drives.
// ============================================================================
// Each drive command (vel_x, vel_y, turn_rate in signed Q2.13, max_pwm) is
// mixed into FL = x+y+t, FR = x-y-t, RL = x-y+t, RR = x+y-t. With M the
// largest demand magnitude and D = max(M, 1.0), each wheel target is
// demand * max_pwm / D rounded toward zero, negated per invert_mask. Each
// stored wheel speed moves toward its target by at most ramp_step, and is
// reported clamped to +-pwm_limit as a direction code (0 off, 1 forward,
// 2 reverse) and a duty. A stop command zeroes all speeds and all outputs.
// A drive command passes from its transfer through the mix state, the search for
// the largest magnitude over the four demands, then for each wheel in turn the
// shared multiplier, the shared restoring divider and the slew step, and then
// the output state. A stop command goes from the mix state straight to the
// output state, with no search, multiply, divide or slew. The input
// is ready only while the sequencer is idle; a finished result may still be
// waiting in the output register while the next command is taken, and the
// sequencer holds its new result until that register is free. Configuration
// writes are always taken (cfg_ready is high) and should only be made while
// no command is in flight; index 3 is ignored.
module mecanum_mixer_with_slew_limit_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Command channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [0:0]  s_action,
    input  logic signed [15:0] s_vel_x,
    input  logic signed [15:0] s_vel_y,
    input  logic signed [15:0] s_turn_rate,
    input  logic [9:0]  s_max_pwm,
    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_fl_dir,
    output logic [9:0]  m_fl_duty,
    output logic [1:0]  m_fr_dir,
    output logic [9:0]  m_fr_duty,
    output logic [1:0]  m_rl_dir,
    output logic [9:0]  m_rl_duty,
    output logic [1:0]  m_rr_dir,
    output logic [9:0]  m_rr_duty,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    // Control state
    mmsl_pkg::state_t                  state_reg, state_next;
    logic [mmsl_pkg::WIDX_W-1:0]       widx_reg, widx_next;
    logic [mmsl_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic                              m_valid_reg, m_valid_next;
    logic [mmsl_pkg::STEP_W-1:0]       ramp_step_reg, ramp_step_next;
    logic [mmsl_pkg::DUTY_W-1:0]       pwm_limit_reg, pwm_limit_next;
    logic [mmsl_pkg::MASK_W-1:0]       inv_mask_reg, inv_mask_next;
    logic signed [mmsl_pkg::SPEED_W-1:0] speed_reg [mmsl_pkg::WHEELS];
    logic signed [mmsl_pkg::SPEED_W-1:0] speed_next [mmsl_pkg::WHEELS];

    // Datapath registers
    logic                              act_reg, act_next;
    logic signed [mmsl_pkg::VEL_W-1:0] vx_reg, vx_next, vy_reg, vy_next, tr_reg, tr_next;
    logic [mmsl_pkg::SCALE_W-1:0]      scale_reg, scale_next;
    logic signed [mmsl_pkg::DEM_W-1:0] dem_reg [mmsl_pkg::WHEELS];
    logic signed [mmsl_pkg::DEM_W-1:0] dem_next [mmsl_pkg::WHEELS];
    logic [mmsl_pkg::MAG_W-1:0]        max_reg, max_next;
    logic [mmsl_pkg::MAG_W-1:0]        rem_reg, rem_next;
    logic [mmsl_pkg::DUTY_W-1:0]       qn_reg, qn_next;
    mmsl_pkg::drive_t                  out_reg [mmsl_pkg::WHEELS];
    mmsl_pkg::drive_t                  out_next [mmsl_pkg::WHEELS];

    // Shared unit signals
    logic signed [mmsl_pkg::DEM_W-1:0] dem_sel;
    logic [mmsl_pkg::MAG_W-1:0]        mag_sel;
    logic [mmsl_pkg::PROD_W-1:0]       prod;
    logic [mmsl_pkg::MAG_W:0]          trial;
    logic                              trial_ge;
    logic                              tgt_neg;
    logic signed [mmsl_pkg::SPEED_W:0] tgt, spd_ext, diff, step_ext, new_spd;
    logic signed [mmsl_pkg::DEM_W-1:0] x_ext, y_ext, t_ext;

    assign s_ready   = (state_reg == mmsl_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;

    assign m_fl_dir  = out_reg[0].dir;
    assign m_fl_duty = out_reg[0].duty;
    assign m_fr_dir  = out_reg[1].dir;
    assign m_fr_duty = out_reg[1].duty;
    assign m_rl_dir  = out_reg[2].dir;
    assign m_rl_duty = out_reg[2].duty;
    assign m_rr_dir  = out_reg[3].dir;
    assign m_rr_duty = out_reg[3].duty;

    // The wheel being worked on drives one multiplier, one divider stage
    // and one slew adder; all four wheels share them in turn.
    assign dem_sel  = dem_reg[widx_reg];
    assign mag_sel  = mmsl_pkg::dem_mag(dem_sel);
    assign prod     = mag_sel * scale_reg;
    assign trial    = {rem_reg, qn_reg[mmsl_pkg::DUTY_W-1]};
    assign trial_ge = (trial >= {1'b0, max_reg});

    assign x_ext = mmsl_pkg::DEM_W'(vx_reg);
    assign y_ext = mmsl_pkg::DEM_W'(vy_reg);
    assign t_ext = mmsl_pkg::DEM_W'(tr_reg);

    // Slew step: the quotient is the target magnitude, its sign comes from
    // the demand and the inversion bit of this wheel.
    always_comb begin
        tgt_neg  = dem_sel[mmsl_pkg::DEM_W-1] ^ inv_mask_reg[widx_reg];
        tgt      = tgt_neg ? -$signed({2'b00, qn_reg}) : $signed({2'b00, qn_reg});
        spd_ext  = (mmsl_pkg::SPEED_W + 1)'(speed_reg[widx_reg]);
        step_ext = $signed({1'b0, ramp_step_reg});
        diff     = tgt - spd_ext;
        if (diff > step_ext) begin
            diff = step_ext;
        end else if (diff < -step_ext) begin
            diff = -step_ext;
        end
        new_spd = spd_ext + diff;
    end

    always_comb begin
        state_next     = state_reg;
        widx_next      = widx_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg;
        ramp_step_next = ramp_step_reg;
        pwm_limit_next = pwm_limit_reg;
        inv_mask_next  = inv_mask_reg;
        act_next       = act_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        tr_next        = tr_reg;
        scale_next     = scale_reg;
        max_next       = max_reg;
        rem_next       = rem_reg;
        qn_next        = qn_reg;
        for (int i = 0; i < mmsl_pkg::WHEELS; i++) begin
            speed_next[i] = speed_reg[i];
            dem_next[i]   = dem_reg[i];
            out_next[i]   = out_reg[i];
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            unique case (mmsl_pkg::cfg_idx_t'(cfg_index))
                mmsl_pkg::CFG_RAMP_STEP:   ramp_step_next = cfg_data;
                mmsl_pkg::CFG_PWM_LIMIT:   pwm_limit_next = cfg_data[mmsl_pkg::DUTY_W-1:0];
                mmsl_pkg::CFG_INVERT_MASK: inv_mask_next  = cfg_data[mmsl_pkg::MASK_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            mmsl_pkg::ST_IDLE: begin
                if (s_valid) begin
                    act_next   = s_action[0];
                    vx_next    = s_vel_x;
                    vy_next    = s_vel_y;
                    tr_next    = s_turn_rate;
                    scale_next = s_max_pwm;
                    state_next = mmsl_pkg::ST_MIX;
                end
            end
            mmsl_pkg::ST_MIX: begin
                if (act_reg) begin
                    for (int i = 0; i < mmsl_pkg::WHEELS; i++) begin
                        speed_next[i] = '0;
                    end
                    state_next = mmsl_pkg::ST_OUT;
                end else begin
                    dem_next[0] = x_ext + y_ext + t_ext;
                    dem_next[1] = x_ext - y_ext - t_ext;
                    dem_next[2] = x_ext - y_ext + t_ext;
                    dem_next[3] = x_ext + y_ext - t_ext;
                    // Starting the search at 1.0 gives max(M, 1.0) directly.
                    max_next    = mmsl_pkg::ONE_Q13;
                    widx_next   = '0;
                    state_next  = mmsl_pkg::ST_MAX;
                end
            end
            mmsl_pkg::ST_MAX: begin
                if (mag_sel > max_reg) begin
                    max_next = mag_sel;
                end
                widx_next = widx_reg + 1'b1;
                if (widx_reg == mmsl_pkg::WHEEL_LAST) begin
                    state_next = mmsl_pkg::ST_MUL;
                end
            end
            mmsl_pkg::ST_MUL: begin
                // The quotient is below 1024, so the upper product bits
                // already lie below the divisor and seed the remainder.
                rem_next   = prod[mmsl_pkg::PROD_W-1:mmsl_pkg::DUTY_W];
                qn_next    = prod[mmsl_pkg::DUTY_W-1:0];
                cnt_next   = '0;
                state_next = mmsl_pkg::ST_DIV;
            end
            mmsl_pkg::ST_DIV: begin
                rem_next = trial_ge ? mmsl_pkg::MAG_W'(trial - {1'b0, max_reg})
                                    : trial[mmsl_pkg::MAG_W-1:0];
                qn_next  = {qn_reg[mmsl_pkg::DUTY_W-2:0], trial_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == mmsl_pkg::DIV_LAST) begin
                    state_next = mmsl_pkg::ST_SLEW;
                end
            end
            mmsl_pkg::ST_SLEW: begin
                speed_next[widx_reg] = new_spd[mmsl_pkg::SPEED_W-1:0];
                widx_next = widx_reg + 1'b1;
                if (widx_reg == mmsl_pkg::WHEEL_LAST) begin
                    state_next = mmsl_pkg::ST_OUT;
                end else begin
                    state_next = mmsl_pkg::ST_MUL;
                end
            end
            mmsl_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    for (int i = 0; i < mmsl_pkg::WHEELS; i++) begin
                        out_next[i] = mmsl_pkg::speed_to_drive(speed_reg[i], pwm_limit_reg);
                    end
                    m_valid_next = 1'b1;
                    state_next   = mmsl_pkg::ST_IDLE;
                end
            end
            default: state_next = mmsl_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mmsl_pkg::ST_IDLE;
            widx_reg      <= '0;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
            ramp_step_reg <= mmsl_pkg::RAMP_STEP_RESET;
            pwm_limit_reg <= mmsl_pkg::PWM_LIMIT_RESET;
            inv_mask_reg  <= mmsl_pkg::INV_MASK_RESET;
            for (int i = 0; i < mmsl_pkg::WHEELS; i++) begin
                speed_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            widx_reg      <= widx_next;
            cnt_reg       <= cnt_next;
            m_valid_reg   <= m_valid_next;
            ramp_step_reg <= ramp_step_next;
            pwm_limit_reg <= pwm_limit_next;
            inv_mask_reg  <= inv_mask_next;
            for (int i = 0; i < mmsl_pkg::WHEELS; i++) begin
                speed_reg[i] <= speed_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        act_reg   <= act_next;
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        tr_reg    <= tr_next;
        scale_reg <= scale_next;
        max_reg   <= max_next;
        rem_reg   <= rem_next;
        qn_reg    <= qn_next;
        for (int i = 0; i < mmsl_pkg::WHEELS; i++) begin
            dem_reg[i] <= dem_next[i];
            out_reg[i] <= out_next[i];
        end
    end

`ifndef ASSERT_OFF
    // The divider remainder always stays below the divisor.
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mmsl_pkg::ST_DIV) |-> (rem_reg < max_reg))
        else $error("divider remainder not below divisor");

    // A wheel speed never leaves the range of a target.
    a_speed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (speed_reg[0] >= -11'sd1023) && (speed_reg[1] >= -11'sd1023) &&
        (speed_reg[2] >= -11'sd1023) && (speed_reg[3] >= -11'sd1023))
        else $error("wheel speed out of range");

    // A result appears only from the output state.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == mmsl_pkg::ST_OUT))
        else $error("result raised outside output state");

    // The front-left and rear-right wheels, when presented, are off exactly when their duty is zero.
    a_off_iff_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (((m_fl_dir == mmsl_pkg::DIR_OFF) == (m_fl_duty == '0)) &&
                         ((m_rr_dir == mmsl_pkg::DIR_OFF) == (m_rr_duty == '0))))
        else $error("direction and duty disagree");
`endif

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking testbench for mecanum_mixer_with_slew_limit_unit.
// ============================================================================
// Drive and stop commands go in over the command channel. The four
// slew-limited wheel drives come back on the result channel. A predictor
// inside this module keeps its own copy of the wheel speeds and of the
// three registers. It computes the drives that each accepted command must
// produce. Every result transfer is checked field by field against the
// oldest prediction.
// ============================================================================
module tb;

    // One command as the block sees it on the command channel.
    typedef struct packed {
        logic                                action;
        logic signed [mmsl_pkg::VEL_W-1:0]   vel_x;
        logic signed [mmsl_pkg::VEL_W-1:0]   vel_y;
        logic signed [mmsl_pkg::VEL_W-1:0]   turn_rate;
        logic [mmsl_pkg::SCALE_W-1:0]        max_pwm;
    } drive_cmd_t;

    // The four wheel drives of one result, index 0 is front left.
    typedef mmsl_pkg::drive_t [mmsl_pkg::WHEELS-1:0] drive_set_t;

    localparam int NUM_PHASES     = 7;
    localparam int PHASE_COMMANDS = 100;
    localparam int CMD_LATENCY    = 60;

    logic                                 aclk;
    logic                                 aresetn;
    logic                                 s_valid;
    logic                                 s_ready;
    logic [0:0]                           s_action;
    logic signed [mmsl_pkg::VEL_W-1:0]    s_vel_x;
    logic signed [mmsl_pkg::VEL_W-1:0]    s_vel_y;
    logic signed [mmsl_pkg::VEL_W-1:0]    s_turn_rate;
    logic [mmsl_pkg::SCALE_W-1:0]         s_max_pwm;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    logic [1:0]                           m_fl_dir;
    logic [mmsl_pkg::DUTY_W-1:0]          m_fl_duty;
    logic [1:0]                           m_fr_dir;
    logic [mmsl_pkg::DUTY_W-1:0]          m_fr_duty;
    logic [1:0]                           m_rl_dir;
    logic [mmsl_pkg::DUTY_W-1:0]          m_rl_duty;
    logic [1:0]                           m_rr_dir;
    logic [mmsl_pkg::DUTY_W-1:0]          m_rr_duty;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [mmsl_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [mmsl_pkg::CFG_DAT_W-1:0]       cfg_data;

    // Predictor state: the registers and the stored wheel speeds, as after reset.
    int                          model_slew   = int'(mmsl_pkg::RAMP_STEP_RESET);
    int                          model_limit  = int'(mmsl_pkg::PWM_LIMIT_RESET);
    logic [mmsl_pkg::MASK_W-1:0] model_invert = mmsl_pkg::INV_MASK_RESET;
    int                          model_speed [mmsl_pkg::WHEELS] = '{default: 0};

    drive_set_t expected_drives [$];
    int         mismatches  = 0;
    bit         no_idle     = 1'b0;
    int         ready_hold  = 0;
    string      wheel_name [mmsl_pkg::WHEELS] = '{"fl", "fr", "rl", "rr"};

    mecanum_mixer_with_slew_limit_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_vel_x     (s_vel_x),
        .s_vel_y     (s_vel_y),
        .s_turn_rate (s_turn_rate),
        .s_max_pwm   (s_max_pwm),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_fl_dir    (m_fl_dir),
        .m_fl_duty   (m_fl_duty),
        .m_fr_dir    (m_fr_dir),
        .m_fr_duty   (m_fr_duty),
        .m_rl_dir    (m_rl_dir),
        .m_rl_duty   (m_rl_duty),
        .m_rr_dir    (m_rr_dir),
        .m_rr_duty   (m_rr_duty),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs. The slowest correct run is about
    // 800 commands, so 5 ms leaves a wide margin.
    initial begin
        #5_000_000;
        $display("mecanum_mixer_with_slew_limit_unit: mismatch");
        $finish;
    end

    // Builds a command from plain integers; values are cut to the port widths.
    function automatic drive_cmd_t drive_cmd(input logic act, input int x, input int y,
                                             input int t, input int pwm);
        drive_cmd_t c;
        c.action    = act;
        c.vel_x     = mmsl_pkg::VEL_W'(x);
        c.vel_y     = mmsl_pkg::VEL_W'(y);
        c.turn_rate = mmsl_pkg::VEL_W'(t);
        c.max_pwm   = mmsl_pkg::SCALE_W'(pwm);
        return c;
    endfunction

    // Works out the four drives that a command produces and advances the
    // stored wheel speeds. A stop clears every speed and every output field.
    // A drive command mixes the three velocities into four wheel demands.
    // It scales them by max_pwm over the larger of the peak magnitude and 1.0,
    // truncating toward zero, and applies the inversion mask. Each speed then
    // steps toward its target by at most the slew step, and is reported after
    // clamping to the duty limit.
    function automatic drive_set_t predict_drive(input drive_cmd_t cmd);
        drive_set_t res;
        int         x, y, t, scale, peak, denom, tgt, delta, s, a;
        int         demand [mmsl_pkg::WHEELS];
        res = '0;
        if (cmd.action) begin
            foreach (model_speed[w]) model_speed[w] = 0;
            return res;
        end
        x     = int'($signed(cmd.vel_x));
        y     = int'($signed(cmd.vel_y));
        t     = int'($signed(cmd.turn_rate));
        scale = int'(cmd.max_pwm);
        demand[0] = x + y + t;
        demand[1] = x - y - t;
        demand[2] = x - y + t;
        demand[3] = x + y - t;
        peak = 0;
        foreach (demand[w]) begin
            a = (demand[w] < 0) ? -demand[w] : demand[w];
            if (a > peak) peak = a;
        end
        // Below 1.0 nothing is normalized.
        denom = (peak > int'(mmsl_pkg::ONE_Q13)) ? peak : int'(mmsl_pkg::ONE_Q13);
        for (int w = 0; w < mmsl_pkg::WHEELS; w++) begin
            tgt = int'(longint'(demand[w]) * longint'(scale) / longint'(denom));
            if (model_invert[w]) tgt = -tgt;
            delta = tgt - model_speed[w];
            if (delta > model_slew) delta = model_slew;
            else if (delta < -model_slew) delta = -model_slew;
            model_speed[w] += delta;
            s = model_speed[w];
            if (s > model_limit) s = model_limit;
            if (s < -model_limit) s = -model_limit;
            if (s > 0) begin
                res[w].dir  = mmsl_pkg::DIR_FWD;
                res[w].duty = mmsl_pkg::DUTY_W'(s);
            end else if (s < 0) begin
                res[w].dir  = mmsl_pkg::DIR_REV;
                res[w].duty = mmsl_pkg::DUTY_W'(-s);
            end
        end
        return res;
    endfunction

    // Sends one command: an optional idle gap, then valid held until the
    // transfer. Valid is left high on return so that back-to-back commands
    // never drop it within one time step. The prediction is queued at the
    // edge on which the command is taken.
    task automatic send_drive(input drive_cmd_t cmd);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_action    <= cmd.action;
        s_vel_x     <= cmd.vel_x;
        s_vel_y     <= cmd.vel_y;
        s_turn_rate <= cmd.turn_rate;
        s_max_pwm   <= cmd.max_pwm;
        do @(posedge aclk); while (!s_ready);
        expected_drives.push_back(predict_drive(cmd));
    endtask

    // Stops sending and waits until every predicted result has been seen,
    // then lets a few more cycles pass so that the block is surely idle.
    task automatic drain_results(input int settle);
        s_valid <= 1'b0;
        while (expected_drives.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    // Writes all three registers back to back and, on request, the unused
    // index, which the block must ignore. The spare upper data bits of the
    // narrower registers carry random values, since only the low bits count.
    task automatic set_config(input int slew, input int limit, input int invert,
                              input bit poke_unused);
        logic [mmsl_pkg::CFG_DAT_W-1:0] data [4];
        mmsl_pkg::cfg_idx_t             idx  [4];
        int                             count;
        idx[0]  = mmsl_pkg::CFG_RAMP_STEP;
        data[0] = mmsl_pkg::CFG_DAT_W'(slew);
        idx[1]  = mmsl_pkg::CFG_PWM_LIMIT;
        data[1] = {1'($urandom), mmsl_pkg::DUTY_W'(limit)};
        idx[2]  = mmsl_pkg::CFG_INVERT_MASK;
        data[2] = {7'($urandom), mmsl_pkg::MASK_W'(invert)};
        idx[3]  = mmsl_pkg::CFG_UNUSED;
        data[3] = mmsl_pkg::CFG_DAT_W'($urandom);
        count   = poke_unused ? 4 : 3;
        for (int i = 0; i < count; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= data[i];
            do @(posedge aclk); while (!cfg_ready);
            case (idx[i])
                mmsl_pkg::CFG_RAMP_STEP:   model_slew   = int'(data[i]);
                mmsl_pkg::CFG_PWM_LIMIT:   model_limit  = int'(data[i][mmsl_pkg::DUTY_W-1:0]);
                mmsl_pkg::CFG_INVERT_MASK: model_invert = data[i][mmsl_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Compares one result transfer with the oldest prediction.
    task automatic check_drive();
        drive_set_t got, want;
        got[0].dir  = mmsl_pkg::dir_t'(m_fl_dir);
        got[0].duty = m_fl_duty;
        got[1].dir  = mmsl_pkg::dir_t'(m_fr_dir);
        got[1].duty = m_fr_duty;
        got[2].dir  = mmsl_pkg::dir_t'(m_rl_dir);
        got[2].duty = m_rl_duty;
        got[3].dir  = mmsl_pkg::dir_t'(m_rr_dir);
        got[3].duty = m_rr_duty;
        if (expected_drives.size() == 0) begin
            $display("%0t: result transfer with no command outstanding", $time);
            mismatches++;
            return;
        end
        want = expected_drives.pop_front();
        for (int w = 0; w < mmsl_pkg::WHEELS; w++) begin
            if (got[w].dir !== want[w].dir) begin
                $display("%0t: %s_dir expected %0d, actual %0d",
                         $time, wheel_name[w], want[w].dir, got[w].dir);
                mismatches++;
            end
            if (got[w].duty !== want[w].duty) begin
                $display("%0t: %s_duty expected %0d, actual %0d",
                         $time, wheel_name[w], want[w].duty, got[w].duty);
                mismatches++;
            end
        end
    endtask

    // Result side: check every transfer, then stall ready for a random
    // number of cycles (none while the no-idle stretch runs).
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            check_drive();
            ready_hold = no_idle ? 0 : $urandom_range(0, 5);
            if (ready_hold != 0) m_ready <= 1'b0;
        end else if (!m_ready) begin
            if (ready_hold <= 1) m_ready <= 1'b1;
            else ready_hold--;
        end
    end

    // With the reset register values: the field extremes, a demand exactly
    // at 1.0, a zero scale, mixed signs and a stop.
    task automatic test_directed_mixing();
        send_drive(drive_cmd(1'b0,   8192,      0,      0, 1023));
        send_drive(drive_cmd(1'b0,  32767,  32767,  32767, 1023));
        send_drive(drive_cmd(1'b0, -32768, -32768, -32768, 1023));
        send_drive(drive_cmd(1'b0,   4096,   4096,      0,  700));
        send_drive(drive_cmd(1'b0,   2000,  -1000,    500,    1));
        send_drive(drive_cmd(1'b0,  32767,  32767,  32767,    0));
        send_drive(drive_cmd(1'b0, -32768,  32767, -32768,  512));
        send_drive(drive_cmd(1'b1,  12345, -12345,     -1, 1023));
        drain_results(4);
    endtask

    // The slew step and the duty clamp at their extremes: an unlimited step
    // reaches any target at once, a zero clamp turns every wheel off, and a
    // zero step freezes the stored speeds.
    task automatic test_ramp_and_limit();
        set_config(2047, 1023, 0, 1'b0);
        send_drive(drive_cmd(1'b0,  32767,      0,      0, 1023));
        send_drive(drive_cmd(1'b0, -32768,      0,      0, 1023));
        drain_results(4);
        set_config(2047, 0, 0, 1'b0);
        send_drive(drive_cmd(1'b0,   8192,   8192,      0, 1023));
        drain_results(4);
        set_config(0, 500, 0, 1'b0);
        send_drive(drive_cmd(1'b0, -8192,    4096,   2048,  900));
        send_drive(drive_cmd(1'b1,     0,       0,      0,    0));
        send_drive(drive_cmd(1'b0,  8192,       0,      0, 1023));
        drain_results(4);
    endtask

    // Direction inversion, wheel by wheel and all at once.
    task automatic test_invert_mask();
        set_config(2047, 1023, 4'b0101, 1'b0);
        send_drive(drive_cmd(1'b0, 6000, 1500, -700, 1023));
        drain_results(4);
        set_config(2047, 1023, 4'b1010, 1'b0);
        send_drive(drive_cmd(1'b0, 6000, 1500, -700, 1023));
        drain_results(4);
        set_config(300, 1023, 4'b1111, 1'b0);
        send_drive(drive_cmd(1'b0, -20000, 9000, 3000, 800));
        send_drive(drive_cmd(1'b0, -20000, 9000, 3000, 800));
        drain_results(4);
    endtask

    // Random commands in phases, each with its own register setting. The
    // first two phases hold the extremes. Most commands stay within the
    // small-demand range so that wheels ramp and settle. The rest use the
    // full field range and force normalization. Stops are sprinkled in.
    task automatic test_random_commands();
        int slew, limit, kind, x, y, t, pwm, pick;
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    slew  = 2047;
                    limit = 1023;
                end
                1: begin
                    slew  = 1;
                    limit = 1;
                end
                default: begin
                    slew  = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 2047)
                                                        : $urandom_range(1, 64);
                    limit = $urandom_range(0, 1023);
                end
            endcase
            set_config(slew, limit, (p == 0) ? 15 : $urandom_range(0, 15), p == 4);
            // One phase runs without any idle cycles on either side.
            no_idle = (p == 2);
            for (int n = 0; n < PHASE_COMMANDS; n++) begin
                kind = $urandom_range(0, 99);
                if (kind < 40) begin
                    x = $urandom;
                    y = $urandom;
                    t = $urandom;
                end else begin
                    x = $urandom_range(0, 8192) - 4096;
                    y = $urandom_range(0, 8192) - 4096;
                    t = $urandom_range(0, 4096) - 2048;
                end
                pick = $urandom_range(0, 9);
                pwm  = (pick == 0) ? 0 : (pick == 1) ? 1023 : $urandom_range(0, 1023);
                send_drive(drive_cmd(kind >= 92, x, y, t, pwm));
                // Once, the sender holds off mid-phase until the block has
                // delivered everything it owes.
                if (p == 3 && n == PHASE_COMMANDS / 2) drain_results(0);
            end
            drain_results(4);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_action    = '0;
        s_vel_x     = '0;
        s_vel_y     = '0;
        s_turn_rate = '0;
        s_max_pwm   = '0;
        cfg_valid   = 1'b0;
        cfg_index   = mmsl_pkg::CFG_RAMP_STEP;
        cfg_data    = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_mixing();
        test_ramp_and_limit();
        test_invert_mask();
        test_random_commands();
        drain_results(CMD_LATENCY);

        if (mismatches == 0) begin
            $display("mecanum_mixer_with_slew_limit_unit: match");
        end else begin
            $display("mecanum_mixer_with_slew_limit_unit: mismatch");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/mmsl_pkg.sv
hdl/mecanum_mixer_with_slew_limit_unit.sv
dv/tb.sv
